/* hw/rtl/iakc_pkg.sv */
// Package for the one-axis image convolution core: sizes, register indexes,
// command codes, sequencer states and a shared helper function. No dependencies.
`default_nettype none
package iakc_pkg;
  localparam int unsigned MaxRadius   = 7;
  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned PixelBits   = 16;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned CoefBits    = CoefFracBits + 2;
  localparam int unsigned Taps        = 2 * MaxRadius + 1;
  localparam int unsigned LineRows    = 2 * MaxRadius;
  localparam int unsigned ValueBits   = 20;
  localparam int unsigned XBits       = $clog2(MaxWidth);
  localparam int unsigned YBits       = $clog2(MaxHeight);
  localparam int unsigned SizeBits    = 11;
  localparam int unsigned TapBits     = $clog2(Taps);
  localparam int unsigned RowBits     = $clog2(LineRows);
  localparam int unsigned LineDepth   = LineRows * MaxWidth;
  localparam int unsigned LineAddrBits = $clog2(LineDepth);
  localparam int unsigned RadBits     = 3;
  // One product plus one pair term, summed over at most Taps terms.
  localparam int unsigned AccBits     = PixelBits + 1 + CoefBits + TapBits + 1;

  typedef enum logic [2:0] {
    RegKernelMode  = 3'd0,
    RegHorizontal  = 3'd1,
    RegRadius      = 3'd2,
    RegImageWidth  = 3'd3,
    RegImageHeight = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ModeGeneral = 2'd0,
    ModeSym     = 2'd1,
    ModeAnti    = 2'd2,
    ModeNone    = 2'd3
  } kernel_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StMac,
    StResult,
    StBorder
  } seq_state_e;

  typedef struct packed {
    logic [XBits-1:0]     x;
    logic [YBits-1:0]     y;
    logic signed [ValueBits-1:0] value;
    logic                 sat;
    logic                 last;
  } result_t;

  // Floor shift and saturation of the accumulator to the result width.
  function automatic logic [ValueBits:0] scale_sat(input logic signed [AccBits-1:0] acc);
    logic signed [AccBits-1:0] q;
    logic signed [AccBits-1:0] hi;
    logic signed [AccBits-1:0] lo;
    q  = acc >>> CoefFracBits;
    hi = AccBits'((64'sd1 <<< (ValueBits - 1)) - 64'sd1);
    lo = -AccBits'(64'sd1 <<< (ValueBits - 1));
    if (q > hi) return {1'b1, hi[ValueBits-1:0]};
    if (q < lo) return {1'b1, lo[ValueBits-1:0]};
    return {1'b0, q[ValueBits-1:0]};
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/iakc_line_ram.sv */
// Line store RAM: one write port and one registered read port.
// Depends on iakc_pkg for its depth and word width.
`default_nettype none
module iakc_line_ram
  import iakc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [LineAddrBits-1:0] waddr_i,
  input  wire logic [PixelBits-1:0]    wdata_i,
  input  wire logic                    re_i,
  input  wire logic [LineAddrBits-1:0] raddr_i,
  output logic      [PixelBits-1:0]    rdata_o
);
  logic [PixelBits-1:0] mem [LineDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/iakc_mac.sv */
// Shared multiply-accumulate: one tap term per cycle, product registered
// before the add. Depends on iakc_pkg.
`default_nettype none
module iakc_mac
  import iakc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic                      en_i,
  input  wire logic signed [PixelBits:0] a_i,
  input  wire logic signed [CoefBits-1:0] c_i,
  output logic signed [AccBits-1:0]      acc_o
);
  logic signed [PixelBits+CoefBits:0] prod_q;
  logic                               pv_q;
  logic signed [AccBits-1:0]          acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) acc_d = '0;
    else if (pv_q) acc_d = acc_q + AccBits'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q  <= en_i;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * c_i;
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

/* hw/rtl/image_axis_kernel_convolution_core.sv */
// Top level of the one-axis image convolution core: config registers,
// coefficient file, row window, sequencer. Uses iakc_pkg, iakc_line_ram, iakc_mac.
//
//  Channel      Dir  Handshake          Payload
//  s_axis       in   tvalid/tready      tuser=cmd, tdata={tap_value,tap_index,pixel}
//  m_axis       out  tvalid/tready      tdata={saturated,value,out_y,out_x}, tlast=last
//  cfg          in   cfg_valid/ready    cfg_index, cfg_data
//
// An interior pixel word is computed by the shared multiplier, fed one tap a cycle
// from the window registers or the line RAM read port. A pixel word yields an
// interior result, a border zero, both, or no word; a coefficient word yields none.
// Reset clears counters, coefficients and config; the line RAM is not cleared.
// A stalled output holds the sequencer in its result or border state and keeps
// s_axis_tready low.
`default_nettype none
module image_axis_kernel_convolution_core
  import iakc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // pixel[15:0], tap_index[19:16], tap_value[35:20]
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_x, out_y, value, saturated from bit 0
  output logic             m_axis_tlast,  // last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  // Configuration.
  logic [1:0]  mode_q;
  logic        horiz_q;
  logic [RadBits-1:0] rad_q;
  logic [SizeBits-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSym; horiz_q <= 1'b1; rad_q <= RadBits'(1);
      width_q <= SizeBits'(MaxWidth); height_q <= SizeBits'(MaxHeight);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegKernelMode:  mode_q   <= cfg_data_i[1:0];
        RegHorizontal:  horiz_q  <= cfg_data_i[0];
        RegRadius:      rad_q    <= cfg_data_i[RadBits-1:0];
        RegImageWidth:  width_q  <= cfg_data_i[SizeBits-1:0];
        RegImageHeight: height_q <= cfg_data_i[SizeBits-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and radius.
  logic [SizeBits-1:0] ew, eh, len;
  logic [RadBits-1:0]  r;
  always_comb begin
    ew = (width_q == '0) ? SizeBits'(1) :
         (width_q > SizeBits'(MaxWidth)) ? SizeBits'(MaxWidth) : width_q;
    eh = (height_q == '0) ? SizeBits'(1) :
         (height_q > SizeBits'(MaxHeight)) ? SizeBits'(MaxHeight) : height_q;
    r  = (rad_q > RadBits'(MaxRadius)) ? RadBits'(MaxRadius) : rad_q;
    len = horiz_q ? ew : eh;
  end

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  logic signed [PixelBits-1:0] in_pix;
  logic [3:0]  in_tap;
  logic signed [CoefBits-1:0] in_coef;
  assign in_pix  = s_axis_tdata[15:0];
  assign in_tap  = s_axis_tdata[19:16];
  assign in_coef = s_axis_tdata[35:20];

  // Coefficients.
  logic signed [CoefBits-1:0] coef_q [Taps];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) coef_q[i] <= '0;
    end else if (in_acc && s_axis_tuser && in_tap < 4'(Taps)) begin
      coef_q[in_tap[TapBits-1:0]] <= in_coef;
    end
  end

  // Row window shift line: tap 0 is the newest pixel.
  logic signed [PixelBits-1:0] win_q [Taps];
  logic pix_acc;
  assign pix_acc = in_acc && !s_axis_tuser;
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      win_q[0] <= in_pix;
      for (int i = 1; i < Taps; i++) win_q[i] <= win_q[i-1];
    end
  end

  // Counters and per-item registers. slot_q follows the row counter modulo
  // the number of stored rows.
  logic [XBits-1:0] x_q;
  logic [YBits-1:0] y_q;
  logic [RowBits-1:0] slot_q;
  logic [XBits-1:0] cx_q;
  logic [YBits-1:0] cy_q;
  logic [RowBits-1:0] cslot_q;
  logic interior_q, border_q;
  seq_state_e st_q, st_d;
  logic [TapBits:0] k_q;      // term counter
  logic [TapBits:0] nterm_q;  // number of terms
  logic [2:0] drain_q;
  logic done_terms;

  logic [SizeBits-1:0] pos_now;
  assign pos_now = horiz_q ? SizeBits'(x_q) : SizeBits'(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; slot_q <= '0;
    end else if (pix_acc) begin
      if ({1'b0, x_q} + 11'd1 >= ew) begin
        x_q <= '0;
        if ({1'b0, y_q} + 11'd1 >= eh) begin
          y_q <= '0;
          slot_q <= '0;
        end else begin
          y_q <= y_q + YBits'(1);
          slot_q <= (slot_q == RowBits'(LineRows - 1)) ? '0 : slot_q + RowBits'(1);
        end
      end else begin
        x_q <= x_q + XBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      cx_q <= x_q; cy_q <= y_q; cslot_q <= slot_q;
      interior_q <= (pos_now >= SizeBits'({r, 1'b0})) && (pos_now < len);
      border_q   <= (pos_now < SizeBits'(r)) || (pos_now + SizeBits'(r) >= len);
      nterm_q <= (mode_q == ModeGeneral) ? (TapBits+1)'({r, 1'b1})
                                        : (TapBits+1)'(r) + (TapBits+1)'(1);
    end
  end

  // Line RAM. Column mode reads its taps from here; paired modes need two taps per pair term.
  logic [LineAddrBits-1:0] waddr, raddr;
  logic [PixelBits-1:0] rdata;
  logic ram_re, ram_we;
  logic [TapBits-1:0] rd_d;
  logic [RowBits-1:0] rrow, rtap;

  // The current pixel is written back only after all reads of its item, since
  // the oldest row of the widest window lives in the same slot.
  assign waddr  = {cslot_q, cx_q};
  assign ram_we = (st_q == StMac);

  // Term walk: term k uses taps d_a (and d_b for paired modes).
  // In paired modes each term fetches A, fetches B, then multiplies; general mode fetches one tap.
  logic phase_q;
  logic [TapBits-1:0] da, db;
  logic signed [PixelBits-1:0] wa_q;
  logic [TapBits-1:0] tap_a_q;  // tap A index of the pair being finished
  always_comb begin
    case (kernel_mode_e'(mode_q))
      ModeGeneral: begin da = TapBits'(k_q); db = TapBits'(k_q); end
      default: begin
        da = TapBits'(r) - TapBits'(k_q);
        db = TapBits'(r) + TapBits'(k_q);
      end
    endcase
  end
  assign rd_d = phase_q ? db : da;
  // Slot of the row d above the current one, wrapped around the stored rows.
  assign rtap = RowBits'(rd_d);
  assign rrow = (rtap > cslot_q) ? cslot_q + RowBits'(LineRows) - rtap : cslot_q - rtap;
  assign raddr = {rrow, cx_q};
  assign ram_re = (st_q == StFetch) && interior_q && !done_terms;

  iakc_line_ram u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(win_q[0]),
    .re_i(ram_re), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Tap value: from window, or RAM data (tap 0 is the current pixel).
  logic rd_pending_q;
  logic [TapBits-1:0] rd_tap_q;
  logic signed [PixelBits-1:0] tapv;
  always_comb begin
    if (horiz_q || rd_tap_q == '0) tapv = win_q[rd_tap_q];
    else tapv = rdata;
  end

  logic mac_en, mac_clr;
  logic signed [PixelBits:0] mac_a;
  logic signed [CoefBits-1:0] mac_c;
  logic signed [AccBits-1:0] acc;
  logic term_phase_q; // set when rd_pending_q carries the B tap

  always_comb begin
    mac_en = 1'b0; mac_a = '0; mac_c = '0;
    if (rd_pending_q && (term_phase_q || kernel_mode_e'(mode_q) == ModeGeneral)) begin
      mac_en = 1'b1;
    end
    if (rd_pending_q) begin
      case (kernel_mode_e'(mode_q))
        ModeGeneral: begin
          mac_a = (PixelBits+1)'(tapv);
          mac_c = coef_q[TapBits'({r, 1'b0}) - rd_tap_q];
        end
        ModeSym: begin
          mac_a = (rd_tap_q == TapBits'(r)) ? (PixelBits+1)'(tapv)
                                            : (PixelBits+1)'(wa_q) + (PixelBits+1)'(tapv);
          mac_c = coef_q[TapBits'(r) + (TapBits'(r) - tap_a_q)];
        end
        ModeAnti: begin
          mac_a = (rd_tap_q == TapBits'(r)) ? '0
                                            : (PixelBits+1)'(wa_q) - (PixelBits+1)'(tapv);
          mac_c = coef_q[TapBits'(r) + (TapBits'(r) - tap_a_q)];
        end
        default: begin mac_a = '0; mac_c = '0; end
      endcase
    end
  end

  assign mac_clr = pix_acc;

  iakc_mac u_mac (
    .clk_i, .rst_ni, .clear_i(mac_clr), .en_i(mac_en),
    .a_i(mac_a), .c_i(mac_c), .acc_o(acc)
  );

  // Sequencer. A pixel that is neither interior nor border yields no word.
  assign done_terms = (k_q == nterm_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:   if (pix_acc) st_d = StFetch;
      StFetch: begin
        if (!interior_q || (done_terms && !phase_q)) st_d = StMac;
      end
      StMac: begin
        if (drain_q == '0) begin
          if (interior_q) st_d = StResult;
          else if (border_q) st_d = StBorder;
          else st_d = StIdle;
        end
      end
      StResult: if (out_acc) st_d = border_q ? StBorder : StIdle;
      StBorder: if (out_acc) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; phase_q <= 1'b0; drain_q <= '0;
      rd_pending_q <= 1'b0; term_phase_q <= 1'b0; rd_tap_q <= '0;
    end else begin
      st_q <= st_d;
      rd_pending_q <= 1'b0;
      if (pix_acc) begin
        k_q <= '0; phase_q <= 1'b0;
      end else if (st_q == StFetch && interior_q && !done_terms) begin
        rd_pending_q <= 1'b1;
        rd_tap_q <= rd_d;
        term_phase_q <= phase_q;
        if (kernel_mode_e'(mode_q) == ModeGeneral || phase_q) begin
          k_q <= k_q + (TapBits+1)'(1);
          phase_q <= 1'b0;
        end else begin
          phase_q <= 1'b1;
        end
      end
      if (st_q == StFetch) drain_q <= 3'd3;
      else if (st_q == StMac && drain_q != '0) drain_q <= drain_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pending_q && !term_phase_q) begin
      wa_q <= tapv; tap_a_q <= rd_tap_q;
    end
  end

  // Output word, formed from the sequencer state and the accumulator.
  logic [ValueBits:0] sv;
  logic signed [AccBits-1:0] acc_use;
  assign acc_use = (kernel_mode_e'(mode_q) == ModeNone) ? '0 : acc;
  assign sv = scale_sat(acc_use);

  result_t res;
  always_comb begin
    res = '0;
    if (st_q == StResult) begin
      res.x = horiz_q ? cx_q - XBits'(r) : cx_q;
      res.y = horiz_q ? cy_q : cy_q - YBits'(r);
      res.value = sv[ValueBits-1:0];
      res.sat = sv[ValueBits];
      res.last = !border_q;
    end else begin
      res.x = cx_q; res.y = cy_q; res.last = 1'b1;
    end
  end

  assign m_axis_tvalid = (st_q == StResult) || (st_q == StBorder);
  assign m_axis_tdata  = {7'd0, res.sat, res.value, res.y, res.x};
  assign m_axis_tlast  = res.last;
  assign s_axis_tready = (st_q == StIdle);

  a_out_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("result while accepting");
  a_result_needs_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StResult) |-> interior_q) else $error("result without interior");
  a_border_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StBorder && !m_axis_tready) |=> st_q == StBorder) else $error("border dropped");
endmodule
`default_nettype wire
